// ===== hw/rtl/ipl_pkg.sv =====
// Shared types and constants for the image plane layout block.
// No dependencies; every other file of the block imports this package.
package ipl_pkg;

   localparam int unsigned WIDTH_W   = 16;
   localparam int unsigned HEIGHT_W  = 16;
   localparam int unsigned ADDR_W    = 48;
   localparam int unsigned LINE_W    = 19;
   localparam int unsigned PROD_W    = 35;
   localparam int unsigned SIZE_W    = 36;
   localparam int unsigned TOTAL_W   = 37;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 12;
   localparam int unsigned PLANES    = 4;

   localparam logic [PROD_W-1:0] PALETTE_BYTES = PROD_W'(256 * 4);

   typedef enum logic [1:0] {
      KIND_PLANAR    = 2'd0,
      KIND_BITSTREAM = 2'd1,
      KIND_PALETTE   = 2'd2,
      KIND_HWACCEL   = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEPS   = 3'd0,
      REG_PLANES  = 3'd1,
      REG_SHIFT_W = 3'd2,
      REG_SHIFT_H = 3'd3,
      REG_KIND    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0] steps;
      logic [7:0]  planes;
      logic [1:0]  shift_w;
      logic [1:0]  shift_h;
      kind_type    kind;
   } cfg_type;

   typedef struct packed {
      kind_type                      kind;
      logic [1:0]                    last_plane;
      logic [PLANES-1:0][LINE_W-1:0] line;
      logic [HEIGHT_W-1:0]           h_full;
      logic [HEIGHT_W-1:0]           h_sub;
      logic [ADDR_W-1:0]             base;
   } desc_type;

endpackage

// ===== hw/rtl/image_plane_layout.sv =====
// Top level of the image plane layout block: format registers, front end,
// descriptor queue and back end. Depends on ipl_pkg and the ipl_* modules.
//
// Each image yields one beat per plane (one to four, two for paletted
// formats, one error beat for hardware formats), issued one beat per clock
// by the back end's plane walker. An accepted image is written to the queue,
// then passes through the back end's stage-one and result registers. A
// two-entry queue lets new images be taken while earlier ones are still
// being emitted; busy rises only when that queue is full. Result beats
// cannot be held off. Format registers are always ready and must only be
// written while no image is in flight.
module image_plane_layout (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ipl_pkg::WIDTH_W-1:0]      req_width,
   input  logic [ipl_pkg::HEIGHT_W-1:0]     req_height,
   input  logic [ipl_pkg::ADDR_W-1:0]       req_base_address,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_plane_index,
   output logic [ipl_pkg::LINE_W-1:0]       rsp_line_bytes,
   output logic [ipl_pkg::ADDR_W-1:0]       rsp_plane_address,
   output logic [ipl_pkg::SIZE_W-1:0]       rsp_plane_bytes,
   output logic [ipl_pkg::TOTAL_W-1:0]      rsp_total_bytes,
   output logic                             rsp_format_error,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ipl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ipl_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import ipl_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc;
   desc_type head;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     accept;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign accept    = start && !q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_STEPS:   cfg_in.steps   = csr_wdata[11:0];
            REG_PLANES:  cfg_in.planes  = csr_wdata[7:0];
            REG_SHIFT_W: cfg_in.shift_w = csr_wdata[1:0];
            REG_SHIFT_H: cfg_in.shift_h = csr_wdata[1:0];
            REG_KIND:    cfg_in.kind    = kind_type'(csr_wdata[1:0]);
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{steps: '0, planes: '0, shift_w: '0, shift_h: '0, kind: KIND_PLANAR};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipl_front u_front (
      .cfg          (cfg_ff),
      .width        (req_width),
      .height       (req_height),
      .base_address (req_base_address),
      .desc         (front_desc)
   );

   ipl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_desc),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   ipl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_not_empty),
      .head              (head),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_plane_index   (rsp_plane_index),
      .rsp_line_bytes    (rsp_line_bytes),
      .rsp_plane_address (rsp_plane_address),
      .rsp_plane_bytes   (rsp_plane_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_format_error  (rsp_format_error),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hw/rtl/ipl_front.sv =====
// Front end: classifies an accepted image against the format registers.
// Depends on ipl_pkg; produces one plane descriptor for the queue.
module ipl_front (
   input  ipl_pkg::cfg_type                 cfg,
   input  logic [ipl_pkg::WIDTH_W-1:0]      width,
   input  logic [ipl_pkg::HEIGHT_W-1:0]     height,
   input  logic [ipl_pkg::ADDR_W-1:0]       base_address,
   output ipl_pkg::desc_type                desc
);
   import ipl_pkg::*;

   function automatic logic [15:0] ceil_shift(input logic [15:0] v, input logic [1:0] s);
      logic [15:0] mask;
      begin
         case (s)
            2'd0:    mask = 16'h0000;
            2'd1:    mask = 16'h0001;
            2'd2:    mask = 16'h0003;
            default: mask = 16'h0007;
         endcase
         ceil_shift = (v >> s) + 16'(|(v & mask));
      end
   endfunction

   logic [3:0]  peak_step [PLANES];
   logic [1:0]  max_comp [PLANES];
   logic        present  [PLANES];
   logic [3:0]  step;
   logic [1:0]  plane;
   logic [1:0]  sw;
   logic [15:0] w_sub;
   logic [19:0] bit_prod;
   logic [1:0]  last_plane;

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         peak_step[p] = 4'd0;
         max_comp[p] = 2'd0;
         present[p]  = 1'b0;
      end
      for (int c = 0; c < PLANES; c++) begin
         step  = {1'b0, cfg.steps[3*c +: 3]} + 4'd1;
         plane = cfg.planes[2*c +: 2];
         present[plane] = 1'b1;
         if (step > peak_step[plane]) begin
            peak_step[plane] = step;
            max_comp[plane] = 2'(c);
         end
      end

      bit_prod = (20'(width) * 20'({1'b0, cfg.steps[2:0]} + 4'd1)) + 20'd7;

      for (int p = 0; p < PLANES; p++) begin
         sw    = (max_comp[p] == 2'd1 || max_comp[p] == 2'd2) ? cfg.shift_w : 2'd0;
         w_sub = ceil_shift(width, sw);
         if (cfg.kind == KIND_BITSTREAM) begin
            desc.line[p] = (p == 0) ? LINE_W'(bit_prod >> 3) : '0;
         end else begin
            desc.line[p] = LINE_W'(20'(peak_step[p]) * 20'(w_sub));
         end
      end

      if (!present[1]) begin
         last_plane = 2'd0;
      end else if (!present[2]) begin
         last_plane = 2'd1;
      end else if (!present[3]) begin
         last_plane = 2'd2;
      end else begin
         last_plane = 2'd3;
      end

      case (cfg.kind)
         KIND_HWACCEL: desc.last_plane = 2'd0;
         KIND_PALETTE: desc.last_plane = 2'd1;
         default:      desc.last_plane = last_plane;
      endcase

      desc.kind   = cfg.kind;
      desc.h_full = height;
      desc.h_sub  = ceil_shift(height, cfg.shift_h);
      desc.base   = base_address;
   end

endmodule

// ===== hw/rtl/ipl_queue.sv =====
// Two-entry queue of plane descriptors between the front and back ends.
// Depends on ipl_pkg for the descriptor type.
module ipl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ipl_pkg::desc_type  push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output ipl_pkg::desc_type  head
);
   import ipl_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ipl_back.sv =====
// Back end: walks the planes of the head descriptor, one per cycle, sizing
// each plane and then placing it in memory. Depends on ipl_pkg.
module ipl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  ipl_pkg::desc_type               head,
   output logic                            pop,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_plane_index,
   output logic [ipl_pkg::LINE_W-1:0]      rsp_line_bytes,
   output logic [ipl_pkg::ADDR_W-1:0]      rsp_plane_address,
   output logic [ipl_pkg::SIZE_W-1:0]      rsp_plane_bytes,
   output logic [ipl_pkg::TOTAL_W-1:0]     rsp_total_bytes,
   output logic                            rsp_format_error,
   output logic                            rsp_last
);
   import ipl_pkg::*;

   logic [1:0]          plane_ff, plane_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [1:0]          s1_plane_ff, s1_plane_in;
   logic [LINE_W-1:0]   s1_line_ff, s1_line_in;
   logic [PROD_W-1:0]   s1_size_ff, s1_size_in;
   logic [ADDR_W-1:0]   s1_base_ff, s1_base_in;
   logic                s1_first_ff, s1_first_in;
   logic                s1_last_ff, s1_last_in;
   logic                s1_err_ff, s1_err_in;
   logic                s1_round_ff, s1_round_in;
   logic [HEIGHT_W-1:0] h;

   logic [ADDR_W-1:0]   acc_addr_ff, acc_addr_in;
   logic [TOTAL_W-1:0]  acc_total_ff, acc_total_in;
   logic [SIZE_W-1:0]   size2;
   logic [ADDR_W-1:0]   addr2;
   logic [TOTAL_W-1:0]  total2;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_plane_ff;
   logic [LINE_W-1:0]   rsp_line_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_err_ff;
   logic                rsp_last_ff;

   always_comb begin
      h           = (plane_ff == 2'd1 || plane_ff == 2'd2) ? head.h_sub : head.h_full;
      s1_valid_in = head_valid;
      s1_plane_in = plane_ff;
      s1_base_in  = head.base;
      s1_first_in = (plane_ff == 2'd0);
      s1_last_in  = (plane_ff == head.last_plane);
      s1_err_in   = (head.kind == KIND_HWACCEL);
      s1_round_in = (head.kind == KIND_PALETTE) && (plane_ff == 2'd0);
      if (head.kind == KIND_HWACCEL) begin
         s1_line_in = '0;
         s1_size_in = '0;
      end else if (head.kind == KIND_PALETTE && plane_ff != 2'd0) begin
         s1_line_in = '0;
         s1_size_in = PALETTE_BYTES;
      end else begin
         s1_line_in = head.line[plane_ff];
         s1_size_in = PROD_W'(head.line[plane_ff]) * PROD_W'(h);
      end
      pop      = head_valid && s1_last_in;
      plane_in = pop ? 2'd0 : (head_valid ? plane_ff + 2'd1 : plane_ff);
   end

   always_comb begin
      size2 = s1_round_ff ? ((SIZE_W'(s1_size_ff) + SIZE_W'(3)) & ~SIZE_W'(3))
                          : SIZE_W'(s1_size_ff);
      if (s1_err_ff) begin
         addr2  = '0;
         total2 = '0;
      end else if (s1_first_ff) begin
         addr2  = s1_base_ff;
         total2 = TOTAL_W'(size2);
      end else begin
         addr2  = acc_addr_ff;
         total2 = acc_total_ff + TOTAL_W'(size2);
      end
      acc_addr_in  = s1_valid_ff ? addr2 + ADDR_W'(size2) : acc_addr_ff;
      acc_total_in = s1_valid_ff ? total2 : acc_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff     <= 2'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plane_ff     <= plane_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_plane_ff  <= s1_plane_in;
      s1_line_ff   <= s1_line_in;
      s1_size_ff   <= s1_size_in;
      s1_base_ff   <= s1_base_in;
      s1_first_ff  <= s1_first_in;
      s1_last_ff   <= s1_last_in;
      s1_err_ff    <= s1_err_in;
      s1_round_ff  <= s1_round_in;
      acc_addr_ff  <= acc_addr_in;
      acc_total_ff <= acc_total_in;
      rsp_plane_ff <= s1_plane_ff;
      rsp_line_ff  <= s1_line_ff;
      rsp_addr_ff  <= addr2;
      rsp_size_ff  <= size2;
      rsp_total_ff <= total2;
      rsp_err_ff   <= s1_err_ff;
      rsp_last_ff  <= s1_last_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_plane_index   = rsp_plane_ff;
   assign rsp_line_bytes    = rsp_line_ff;
   assign rsp_plane_address = rsp_addr_ff;
   assign rsp_plane_bytes   = rsp_size_ff;
   assign rsp_total_bytes   = rsp_total_ff;
   assign rsp_format_error  = rsp_err_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== tb/image_plane_layout_tb.sv =====
// Self-checking testbench for image_plane_layout: directed format and extent cases, then random
// formats and images, with every result beat compared against an expected beat from the directed
// table or a local plane layout model. Depends on ipl_pkg and the image_plane_layout RTL.
module image_plane_layout_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipl_pkg::*;

   typedef struct packed {
      logic [1:0]         plane_index;
      logic [LINE_W-1:0]  line_bytes;
      logic [ADDR_W-1:0]  plane_address;
      logic [SIZE_W-1:0]  plane_bytes;
      logic [TOTAL_W-1:0] total_bytes;
      logic               format_error;
      logic               last;
   } plane_beat_type;

   typedef struct packed {
      cfg_type              fmt;
      logic [WIDTH_W-1:0]   width;
      logic [HEIGHT_W-1:0]  height;
      logic [ADDR_W-1:0]    base;
      logic                 typed;
      plane_beat_type       beat;
   } image_row_type;

   localparam int unsigned    CYCLE_LIMIT = 100000;
   localparam plane_beat_type NO_BEAT     = '0;
   localparam plane_beat_type HW_ERROR    = '{2'd0, 19'd0, 48'h0, 36'h0, 37'h0, 1'b1, 1'b1};

   localparam cfg_type FMT_RESET     = '{12'h000, 8'h00, 2'd0, 2'd0, KIND_PLANAR};
   localparam cfg_type FMT_YUV420    = '{12'h000, 8'h24, 2'd1, 2'd1, KIND_PLANAR};
   localparam cfg_type FMT_YUVA_WIDE = '{12'hFFF, 8'hE4, 2'd3, 2'd3, KIND_PLANAR};
   localparam cfg_type FMT_PACKED_C1 = '{12'h059, 8'h00, 2'd2, 2'd2, KIND_PLANAR};
   localparam cfg_type FMT_TIED      = '{12'h492, 8'h00, 2'd2, 2'd0, KIND_PLANAR};
   localparam cfg_type FMT_GAP1      = '{12'h000, 8'h28, 2'd1, 2'd1, KIND_PLANAR};
   localparam cfg_type FMT_GAP2      = '{12'h249, 8'hD4, 2'd0, 2'd2, KIND_PLANAR};
   localparam cfg_type FMT_MONO      = '{12'h000, 8'h00, 2'd0, 2'd0, KIND_BITSTREAM};
   localparam cfg_type FMT_BITS8     = '{12'h007, 8'hE4, 2'd1, 2'd1, KIND_BITSTREAM};
   localparam cfg_type FMT_PAL8      = '{12'h000, 8'h00, 2'd0, 2'd0, KIND_PALETTE};
   localparam cfg_type FMT_HW        = '{12'hABC, 8'h5A, 2'd2, 2'd1, KIND_HWACCEL};

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   logic [WIDTH_W-1:0]   req_width        = '0;
   logic [HEIGHT_W-1:0]  req_height       = '0;
   logic [ADDR_W-1:0]    req_base_address = '0;
   logic                 rsp_valid;
   logic [1:0]           rsp_plane_index;
   logic [LINE_W-1:0]    rsp_line_bytes;
   logic [ADDR_W-1:0]    rsp_plane_address;
   logic [SIZE_W-1:0]    rsp_plane_bytes;
   logic [TOTAL_W-1:0]   rsp_total_bytes;
   logic                 rsp_format_error;
   logic                 rsp_last;
   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CSR_DAT_W-1:0] csr_wdata        = '0;

   cfg_type        active_fmt = FMT_RESET;
   plane_beat_type pending_planes [$];
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    sender_idle_pct = 15;

   image_row_type directed_rows [22] = '{
      '{FMT_RESET, 16'd0, 16'd0, 48'h0, 1'b1,
        '{2'd0, 19'd0, 48'h0, 36'h0, 37'h0, 1'b0, 1'b1}},
      '{FMT_RESET, 16'd65535, 16'd65535, 48'hFFFF_FFFF_FFFF, 1'b1,
        '{2'd0, 19'd65535, 48'hFFFF_FFFF_FFFF, 36'h0_FFFE_0001, 37'h0_FFFE_0001, 1'b0, 1'b1}},
      '{FMT_RESET, 16'd1, 16'd1, 48'h1234_5678_9ABC, 1'b1,
        '{2'd0, 19'd1, 48'h1234_5678_9ABC, 36'd1, 37'd1, 1'b0, 1'b1}},
      '{FMT_YUV420, 16'd65535, 16'd65535, 48'hFFFF_FFFF_0000, 1'b0, NO_BEAT},
      '{FMT_YUV420, 16'd1, 16'd1, 48'h0000_0000_1000, 1'b0, NO_BEAT},
      '{FMT_YUV420, 16'd0, 16'd7, 48'h5555_AAAA_5555, 1'b0, NO_BEAT},
      '{FMT_YUVA_WIDE, 16'd65535, 16'd65535, 48'hFFFF_FFFF_FFFF, 1'b0, NO_BEAT},
      '{FMT_YUVA_WIDE, 16'd9, 16'd9, 48'hAAAA_5555_AAAA, 1'b0, NO_BEAT},
      '{FMT_PACKED_C1, 16'd5, 16'd3, 48'h0000_0001_0000, 1'b0, NO_BEAT},
      '{FMT_PACKED_C1, 16'd65535, 16'd2, 48'h0, 1'b0, NO_BEAT},
      '{FMT_TIED, 16'd7, 16'd5, 48'h0000_0000_0040, 1'b0, NO_BEAT},
      '{FMT_GAP1, 16'd100, 16'd50, 48'h0000_1000_0000, 1'b0, NO_BEAT},
      '{FMT_GAP2, 16'd100, 16'd51, 48'h0000_2000_0000, 1'b0, NO_BEAT},
      '{FMT_MONO, 16'd65535, 16'd65535, 48'h0000_3000_0000, 1'b0, NO_BEAT},
      '{FMT_MONO, 16'd1, 16'd1, 48'h0, 1'b0, NO_BEAT},
      '{FMT_BITS8, 16'd13, 16'd3, 48'h0000_0000_0100, 1'b0, NO_BEAT},
      '{FMT_PAL8, 16'd3, 16'd1, 48'h0000_0000_0200, 1'b0, NO_BEAT},
      '{FMT_PAL8, 16'd65535, 16'd65535, 48'hFFFF_FFFF_FF00, 1'b0, NO_BEAT},
      '{FMT_PAL8, 16'd0, 16'd0, 48'h0, 1'b0, NO_BEAT},
      '{FMT_HW, 16'd65535, 16'd65535, 48'hFFFF_FFFF_FFFF, 1'b1, HW_ERROR},
      '{FMT_HW, 16'd0, 16'd0, 48'h0, 1'b1, HW_ERROR},
      '{FMT_RESET, 16'd300, 16'd200, 48'h8000_0000_0000, 1'b1,
        '{2'd0, 19'd300, 48'h8000_0000_0000, 36'd60000, 37'd60000, 1'b0, 1'b1}}
   };

   image_plane_layout u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_width         (req_width),
      .req_height        (req_height),
      .req_base_address  (req_base_address),
      .rsp_valid         (rsp_valid),
      .rsp_plane_index   (rsp_plane_index),
      .rsp_line_bytes    (rsp_line_bytes),
      .rsp_plane_address (rsp_plane_address),
      .rsp_plane_bytes   (rsp_plane_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_format_error  (rsp_format_error),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void lay_out_planes(input logic [WIDTH_W-1:0] width,
                                          input logic [HEIGHT_W-1:0] height,
                                          input logic [ADDR_W-1:0] base);
      logic [3:0]        top_step [PLANES];
      int                top_comp [PLANES];
      bit                used [PLANES];
      logic [63:0]       line [PLANES];
      logic [63:0]       size;
      logic [63:0]       total;
      logic [63:0]       extent;
      logic [3:0]        step;
      logic [1:0]        p;
      logic [ADDR_W-1:0] addr;
      int                shift;
      int                n;
      plane_beat_type    beat [PLANES];

      if (active_fmt.kind == KIND_HWACCEL) begin
         pending_planes.push_back(HW_ERROR);
         return;
      end
      for (int i = 0; i < PLANES; i++) begin
         top_step[i] = '0;
         top_comp[i] = 0;
         used[i]     = 1'b0;
         line[i]     = '0;
      end
      for (int i = 0; i < PLANES; i++) begin
         step = {1'b0, active_fmt.steps[3*i +: 3]} + 4'd1;
         p    = active_fmt.planes[2*i +: 2];
         used[p] = 1'b1;
         if (step > top_step[p]) begin
            top_step[p] = step;
            top_comp[p] = i;
         end
      end
      if (active_fmt.kind == KIND_BITSTREAM) begin
         line[0] = (64'(width) * (64'(active_fmt.steps[2:0]) + 64'd1) + 64'd7) >> 3;
      end else begin
         for (int i = 0; i < PLANES; i++) begin
            shift  = (top_comp[i] == 1 || top_comp[i] == 2) ? int'(active_fmt.shift_w) : 0;
            extent = (64'(width) + (64'd1 << shift) - 64'd1) >> shift;
            line[i] = 64'(top_step[i]) * extent;
         end
      end
      addr = base;
      size = line[0] * 64'(height);
      if (active_fmt.kind == KIND_PALETTE) begin
         size = (size + 64'd3) & ~64'd3;
         pending_planes.push_back('{2'd0, line[0][LINE_W-1:0], addr, size[SIZE_W-1:0],
                                    size[TOTAL_W-1:0], 1'b0, 1'b0});
         addr  = addr + size[ADDR_W-1:0];
         total = size + 64'(PALETTE_BYTES);
         pending_planes.push_back('{2'd1, 19'd0, addr, SIZE_W'(PALETTE_BYTES),
                                    total[TOTAL_W-1:0], 1'b0, 1'b1});
         return;
      end
      total   = size;
      beat[0] = '{2'd0, line[0][LINE_W-1:0], addr, size[SIZE_W-1:0], total[TOTAL_W-1:0],
                  1'b0, 1'b0};
      n = 1;
      for (int i = 1; i < PLANES && used[i]; i++) begin
         shift  = (i == 1 || i == 2) ? int'(active_fmt.shift_h) : 0;
         extent = (64'(height) + (64'd1 << shift) - 64'd1) >> shift;
         addr   = addr + size[ADDR_W-1:0];
         size   = extent * line[i];
         total  = total + size;
         beat[n] = '{2'(i), line[i][LINE_W-1:0], addr, size[SIZE_W-1:0], total[TOTAL_W-1:0],
                     1'b0, 1'b0};
         n++;
      end
      beat[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) begin
         pending_planes.push_back(beat[i]);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [15:0] pick_extent();
      int sel;

      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return 16'd0;
      end else if (sel == 1) begin
         return 16'hFFFF;
      end else if (sel < 6) begin
         return 16'($urandom_range(1, 64));
      end
      return 16'($urandom);
   endfunction

   task automatic send_image(input logic [WIDTH_W-1:0] width, input logic [HEIGHT_W-1:0] height,
                             input logic [ADDR_W-1:0] base, input logic typed,
                             input plane_beat_type beat);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_width        <= width;
      req_height       <= height;
      req_base_address <= base;
      do @(posedge clock); while (busy);
      if (typed) begin
         pending_planes.push_back(beat);
      end else begin
         lay_out_planes(width, height, base);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_planes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_format(input cfg_type f);
      logic [CSR_DAT_W-1:0] data;
      logic [CSR_IDX_W-1:0] idx;

      for (int k = REG_STEPS; k <= REG_KIND + 1; k++) begin
         data = CSR_DAT_W'($urandom);
         idx  = CSR_IDX_W'(k);
         case (k)
            REG_STEPS:   data       = f.steps;
            REG_PLANES:  data[7:0]  = f.planes;
            REG_SHIFT_W: data[1:0]  = f.shift_w;
            REG_SHIFT_H: data[1:0]  = f.shift_h;
            REG_KIND:    data[1:0]  = f.kind;
            default:     idx        = REG_KIND + CSR_IDX_W'($urandom_range(1, 3));
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= data;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid  <= 1'b0;
      active_fmt  = f;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      plane_beat_type want;

      if (!reset && rsp_valid) begin
         if (pending_planes.size() == 0) begin
            $display("%0t ns: result beat with none expected, plane %0d", $time,
                     rsp_plane_index);
            mismatch_count++;
         end else begin
            want = pending_planes.pop_front();
            check_field("plane_index", 64'(want.plane_index), 64'(rsp_plane_index));
            check_field("line_bytes", 64'(want.line_bytes), 64'(rsp_line_bytes));
            check_field("plane_address", 64'(want.plane_address), 64'(rsp_plane_address));
            check_field("plane_bytes", 64'(want.plane_bytes), 64'(rsp_plane_bytes));
            check_field("total_bytes", 64'(want.total_bytes), 64'(rsp_total_bytes));
            check_field("format_error", 64'(want.format_error), 64'(rsp_format_error));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   initial begin
      cfg_type             f;
      int                  nplanes;
      logic [ADDR_W-1:0]   base;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].fmt != active_fmt) begin
            settle();
            load_format(directed_rows[r].fmt);
         end
         send_image(directed_rows[r].width, directed_rows[r].height, directed_rows[r].base,
                    directed_rows[r].typed, directed_rows[r].beat);
      end

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 65 : 0;
         for (int c = 0; c < 7; c++) begin
            if (c == 0) begin
               f = '{12'hFFF, 8'hFF, 2'd3, 2'd3, KIND_PLANAR};
            end else if (c == 1) begin
               f = FMT_RESET;
            end else begin
               f.steps   = 12'($urandom);
               f.planes  = 8'($urandom);
               f.shift_w = 2'($urandom);
               f.shift_h = 2'($urandom);
               // Most formats keep their planes contiguous so that every plane gets used.
               if ($urandom_range(0, 3) != 0) begin
                  nplanes = $urandom_range(1, PLANES);
                  for (int i = 0; i < PLANES; i++) begin
                     f.planes[2*i +: 2] = (i < nplanes) ? 2'(i)
                                                        : 2'($urandom_range(0, nplanes - 1));
                  end
               end
               case ($urandom_range(0, 9))
                  5, 6:    f.kind = KIND_BITSTREAM;
                  7, 8:    f.kind = KIND_PALETTE;
                  9:       f.kind = KIND_HWACCEL;
                  default: f.kind = KIND_PLANAR;
               endcase
            end
            settle();
            load_format(f);
            repeat (10) begin
               base = {16'($urandom), 32'($urandom)};
               if ($urandom_range(0, 7) == 0) begin
                  base[ADDR_W-1:16] = '1;
               end
               send_image(pick_extent(), pick_extent(), base, 1'b0, NO_BEAT);
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
